FILE: rtl/core/rph_pkg.sv
// ----------------------------------------------------------------------------
// rph_pkg
// Shared types and codes for the request priority heap.
// ----------------------------------------------------------------------------
package rph_pkg;

  localparam int ENTRY_W = 80;  // arrival_time, request_id, burnout_time

  typedef enum logic [1:0] {
    ST_PUSHED  = 2'd0,
    ST_POPPED  = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef struct packed {
    logic [31:0] burnout_time;
    logic [15:0] request_id;
    logic [31:0] arrival_time;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic load_in;     // capture input request into cur
    logic cap_cur;     // capture read data into cur (last entry on pop)
    logic cap_a;       // capture read data into reg a
    logic cap_b;       // capture read data into reg b
    logic cap_top;     // capture read data as popped root
    logic res_load;    // load the output entry register
    logic res_pop;     // output entry is the popped root, else zero
  } dp_cmd_t;

  // true when x must sit above y
  function automatic logic ranks_before(input entry_t x, input entry_t y,
                                        input logic mode);
    if (mode && x.burnout_time != y.burnout_time)
      return x.burnout_time < y.burnout_time;
    if (x.arrival_time != y.arrival_time)
      return x.arrival_time < y.arrival_time;
    return x.request_id < y.request_id;
  endfunction

endpackage

FILE: rtl/core/rph_ram.sv
// ----------------------------------------------------------------------------
// rph_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module rph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    if (re) rdata <= mem[addr];
  end

endmodule

FILE: rtl/core/rph_ctrl.sv
// ----------------------------------------------------------------------------
// rph_ctrl
// Sequencer for heap push (sift up) and pop (sift down). Holds the
// position and size, drives the RAM, compares through the datapath.
// ----------------------------------------------------------------------------
module rph_ctrl import rph_pkg::*; #(
  parameter int CAPACITY = 64,
  localparam int AW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output status_t       out_status,
  output logic [CW-1:0] out_count,
  input  logic          mode,
  input  entry_t        cur,
  input  entry_t        ra,
  input  entry_t        rb,
  output dp_cmd_t       cmd,
  output logic          ram_we,
  output logic          ram_re,
  output logic [AW-1:0] ram_addr,
  output logic [1:0]    wsel     // 0 cur, 1 ra, 2 rb
);

  typedef enum logic [3:0] {
    S_IDLE, S_UP_RD, S_UP_WT, S_UP_CMP,
    S_POP_RD0, S_POP_RDL, S_POP_CAPL,
    S_DN_RDL, S_DN_RDR, S_DN_CAPL, S_DN_CMP,
    S_WRITE, S_DONE
  } state_t;

  state_t         state;
  status_t        op_status;
  logic [CW-1:0]  count;
  logic [CW-1:0]  pos;       // wide enough for child index compare
  logic [CW:0]    left;
  logic           right_ok;
  logic           res_load;  // result moves into the output register

  assign in_ready = (state == S_IDLE);
  assign left     = {pos, 1'b1};
  assign res_load = (state == S_DONE) && (!out_valid || out_ready);

  logic pick_l, pick_r;
  logic [CW:0] l_idx;
  always_comb begin
    l_idx  = left;
    pick_l = (left < (CW+1)'(count)) && ranks_before(ra, cur, mode);
    pick_r = right_ok && ranks_before(rb, pick_l ? ra : cur, mode);
  end

  always_comb begin
    cmd      = '0;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    ram_addr = pos[AW-1:0];
    wsel     = 2'd0;
    case (state)
      S_IDLE: begin
        cmd.load_in = in_valid && in_ready;
        ram_re      = in_valid && in_ready && in_cmd;
        ram_addr    = '0;
      end
      S_UP_RD: begin
        ram_re   = 1'b1;
        ram_addr = AW'((pos - 1'b1) >> 1);
      end
      S_UP_WT:  cmd.cap_a = 1'b1;
      S_POP_RD0: cmd.cap_top = 1'b1;
      S_POP_RDL: begin
        ram_re   = 1'b1;
        ram_addr = count[AW-1:0];
      end
      S_POP_CAPL: cmd.cap_cur = 1'b1;  // last entry becomes the moving entry
      S_DN_RDL: begin
        ram_re   = 1'b1;
        ram_addr = l_idx[AW-1:0];
      end
      S_DN_RDR: begin
        ram_re   = 1'b1;
        ram_addr = AW'(l_idx + 1'b1);
        cmd.cap_a = 1'b1;
      end
      S_DN_CAPL: cmd.cap_b = 1'b1;
      S_WRITE: begin
        ram_we = 1'b1;
        wsel   = 2'd0;
      end
      S_UP_CMP: begin
        if (ranks_before(cur, ra, mode)) begin
          ram_we = 1'b1;
          wsel   = 2'd1;   // parent moves down into pos
        end
      end
      S_DN_CMP: begin
        if (pick_l || pick_r) begin
          ram_we = 1'b1;
          wsel   = pick_r ? 2'd2 : 2'd1;  // child moves up into pos
        end
      end
      default: ;
    endcase
    cmd.res_load = res_load;
    cmd.res_pop  = (op_status == ST_POPPED);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      pos        <= '0;
      out_valid  <= 1'b0;
      out_status <= ST_PUSHED;
      out_count  <= '0;
      op_status  <= ST_PUSHED;
      right_ok   <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid  <= 1'b1;
        out_status <= op_status;
        out_count  <= count;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            if (!in_cmd) begin
              if (count == CW'(CAPACITY)) begin
                op_status <= ST_FULL;
                state     <= S_DONE;
              end else begin
                pos       <= count;
                count     <= count + 1'b1;
                op_status <= ST_PUSHED;
                state     <= (count == '0) ? S_WRITE : S_UP_RD;
              end
            end else begin
              if (count == '0) begin
                op_status <= ST_EMPTY;
                state     <= S_DONE;
              end else begin
                count     <= count - 1'b1;
                op_status <= ST_POPPED;
                pos       <= '0;
                state     <= S_POP_RD0;
              end
            end
          end
        end
        S_UP_RD: state <= S_UP_WT;
        S_UP_WT: state <= S_UP_CMP;
        S_UP_CMP: begin
          if (ranks_before(cur, ra, mode)) begin
            pos   <= (pos - 1'b1) >> 1;
            state <= (((pos - 1'b1) >> 1) == '0) ? S_WRITE : S_UP_RD;
          end else begin
            state <= S_WRITE;
          end
        end
        S_POP_RD0: state <= (count == '0) ? S_DONE : S_POP_RDL;
        S_POP_RDL: state <= S_POP_CAPL;
        S_POP_CAPL: state <= S_DN_RDL;
        S_DN_RDL: begin
          if (l_idx >= (CW+1)'(count)) state <= S_WRITE;
          else state <= S_DN_RDR;
        end
        S_DN_RDR: begin
          right_ok <= (l_idx + 1'b1) < (CW+1)'(count);
          state    <= S_DN_CAPL;
        end
        S_DN_CAPL: state <= S_DN_CMP;
        S_DN_CMP: begin
          if (pick_r) begin
            pos   <= CW'(l_idx + 1'b1);
            state <= S_DN_RDL;
          end else if (pick_l) begin
            pos   <= CW'(l_idx);
            state <= S_DN_RDL;
          end else begin
            state <= S_WRITE;
          end
        end
        S_WRITE: state <= S_DONE;
        S_DONE: begin
          if (res_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY)) else $error("count beyond capacity");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("ready while busy");
  a_done_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |=> out_valid) else $error("result not raised");
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_status) && $stable(out_count)))
    else $error("result changed while stalled");
`endif

endmodule

FILE: rtl/core/rph_datapath.sv
// ----------------------------------------------------------------------------
// rph_datapath
// Heap storage and entry registers: moving entry, two children/parent, root.
// ----------------------------------------------------------------------------
module rph_datapath import rph_pkg::*; #(
  parameter int CAPACITY = 64,
  localparam int AW = $clog2(CAPACITY)
) (
  input  logic          clk,
  input  dp_cmd_t       cmd,
  input  entry_t        in_entry,
  input  logic          ram_we,
  input  logic          ram_re,
  input  logic [AW-1:0] ram_addr,
  input  logic [1:0]    wsel,
  output entry_t        cur,
  output entry_t        ra,
  output entry_t        rb,
  output entry_t        res
);

  logic [ENTRY_W-1:0] rdata;
  entry_t             wdata;
  entry_t             top;

  always_comb begin
    case (wsel)
      2'd1:    wdata = ra;
      2'd2:    wdata = rb;
      default: wdata = cur;
    endcase
  end

  rph_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    // in pop, the last entry replaces the input as the moving entry
    if (cmd.load_in) cur <= in_entry;
    else if (cmd.cap_cur) cur <= entry_t'(rdata);
    if (cmd.cap_top) top <= entry_t'(rdata);
    if (cmd.cap_a) ra <= entry_t'(rdata);
    if (cmd.cap_b) rb <= entry_t'(rdata);
    if (cmd.res_load) res <= cmd.res_pop ? top : '0;
  end

endmodule

FILE: rtl/core/request_priority_heap.sv
// ----------------------------------------------------------------------------
// request_priority_heap
// Binary min-heap priority queue of requests.
// ----------------------------------------------------------------------------
// Input stream s_axis: one request per item; tuser is the command (0 push,
// 1 pop), tdata carries the request. Output m_axis: one result per request,
// tdata carries occupancy and the popped entry, tuser the status.
// The heap sits on a single RAM port: each level going up reads the parent,
// registers the read data, then compares and moves; each level going down
// reads the left child, reads the right child, captures, then compares and
// moves. One request is in flight at a time; the next is taken the cycle
// after the result is loaded into the output register. If the receiver
// stalls, the result holds in the output register; the next request still
// runs, then waits for the register with tready low. scheduler_mode is to be
// written through cfg_we/cfg_data only while idle; the block itself does not
// enforce this. Reset clears occupancy, mode and tvalid; slot contents stay
// undefined. Pushing to a full heap and popping an empty one return a flag
// status.
// ----------------------------------------------------------------------------
module request_priority_heap import rph_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic         cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [79:0]  s_axis_tdata,   // arrival_time, request_id, burnout_time
  input  logic         s_axis_tuser,   // cmd
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [87:0]  m_axis_tdata,   // out_arrival_time, out_request_id,
                                       // out_burnout_time, occupancy, pad
  output logic [1:0]   m_axis_tuser    // status
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic          mode;
  dp_cmd_t       cmd;
  entry_t        cur, ra, rb, res;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_addr;
  logic [1:0]    wsel;
  status_t       st;
  logic [CW-1:0] occ;

  always_ff @(posedge clk) begin
    if (rst) mode <= 1'b0;
    else if (cfg_we) mode <= cfg_data;
  end

  rph_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_cmd(s_axis_tuser),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_status(st), .out_count(occ), .mode(mode),
    .cur(cur), .ra(ra), .rb(rb), .cmd(cmd),
    .ram_we(ram_we), .ram_re(ram_re), .ram_addr(ram_addr), .wsel(wsel)
  );

  rph_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .clk(clk), .cmd(cmd),
    .in_entry(entry_t'(s_axis_tdata)),
    .ram_we(ram_we), .ram_re(ram_re), .ram_addr(ram_addr), .wsel(wsel),
    .cur(cur), .ra(ra), .rb(rb), .res(res)
  );

  assign m_axis_tdata = {1'b0, 7'(occ), res};
  assign m_axis_tuser = st;

endmodule

FILE: test/request_priority_heap_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// request_priority_heap_tb
// Drives pushes and pops in both order modes with bursty input and a
// stalling receiver; a heap model predicts every result for comparison.
// ----------------------------------------------------------------------------
class heap_scoreboard;
  logic [31:0] h_enter [64];
  logic [15:0] h_id    [64];
  logic [31:0] h_burn  [64];
  int unsigned count;
  bit mode;
  logic [87:0] want_data [$];
  logic [1:0]  want_status [$];
  int errors;

  function new();
    count = 0;
    mode = 0;
    errors = 0;
  endfunction

  function bit above(int unsigned x, int unsigned y);
    if (mode && h_burn[x] != h_burn[y]) return h_burn[x] < h_burn[y];
    if (h_enter[x] != h_enter[y]) return h_enter[x] < h_enter[y];
    return h_id[x] < h_id[y];
  endfunction

  function void swap(int unsigned x, int unsigned y);
    logic [31:0] t32;
    logic [15:0] t16;
    t32 = h_enter[x]; h_enter[x] = h_enter[y]; h_enter[y] = t32;
    t16 = h_id[x]; h_id[x] = h_id[y]; h_id[y] = t16;
    t32 = h_burn[x]; h_burn[x] = h_burn[y]; h_burn[y] = t32;
  endfunction

  // note one accepted request and queue its expected result
  function void note_request(logic cmd, logic [79:0] d);
    logic [1:0] st;
    logic [31:0] oe, ob;
    logic [15:0] oi;
    int unsigned pos, par, best, l, r;
    oe = 0; oi = 0; ob = 0;
    if (cmd == 1'b0) begin
      if (count >= 64) begin
        st = rph_pkg::ST_FULL;
      end else begin
        pos = count;
        h_enter[pos] = d[31:0];
        h_id[pos] = d[47:32];
        h_burn[pos] = d[79:48];
        count++;
        while (pos > 0) begin
          par = (pos - 1) / 2;
          if (!above(pos, par)) break;
          swap(pos, par);
          pos = par;
        end
        st = rph_pkg::ST_PUSHED;
      end
    end else if (count == 0) begin
      st = rph_pkg::ST_EMPTY;
    end else begin
      oe = h_enter[0]; oi = h_id[0]; ob = h_burn[0];
      count--;
      h_enter[0] = h_enter[count];
      h_id[0] = h_id[count];
      h_burn[0] = h_burn[count];
      pos = 0;
      forever begin
        best = pos;
        l = 2 * pos + 1;
        r = l + 1;
        if (l < count && above(l, best)) best = l;
        if (r < count && above(r, best)) best = r;
        if (best == pos) break;
        swap(pos, best);
        pos = best;
      end
      st = rph_pkg::ST_POPPED;
    end
    want_status.push_back(st);
    want_data.push_back({1'b0, 7'(count), ob, oi, oe});
  endfunction

  function void check_result(logic [87:0] d, logic [1:0] st);
    logic [87:0] w;
    logic [1:0] ws;
    if (want_data.size() == 0) begin
      $error("unexpected result data=%h status=%0d", d, st);
      errors++;
      return;
    end
    w = want_data.pop_front();
    ws = want_status.pop_front();
    if (st !== ws) begin
      $error("status expected %0d actual %0d", ws, st); errors++;
    end
    if (d[31:0] !== w[31:0]) begin
      $error("out_arrival_time expected %h actual %h", w[31:0], d[31:0]); errors++;
    end
    if (d[47:32] !== w[47:32]) begin
      $error("out_request_id expected %h actual %h", w[47:32], d[47:32]); errors++;
    end
    if (d[79:48] !== w[79:48]) begin
      $error("out_burnout_time expected %h actual %h", w[79:48], d[79:48]); errors++;
    end
    if (d[86:80] !== w[86:80]) begin
      $error("occupancy expected %0d actual %0d", w[86:80], d[86:80]); errors++;
    end
  endfunction
endclass

module request_priority_heap_tb;
  import rph_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic cfg_data = 0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic s_axis_tuser = 0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [87:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;

  heap_scoreboard sb = new();
  int unsigned cycles = 0;
  int unsigned burst_left = 0;
  bit stall_on = 0;

  always #1 clk = ~clk;

  request_priority_heap #(.CAPACITY(64)) DUT (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("request_priority_heap_tb failed");
      $finish;
    end
    if (!rst && s_axis_tvalid && s_axis_tready) sb.note_request(s_axis_tuser, s_axis_tdata);
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
  end

  // receiver: long no-stall stretches alternate with random stalling
  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_on <= ~stall_on;
    m_axis_tready <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
  end

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  task automatic send(logic cmd, logic [31:0] et, logic [15:0] id, logic [31:0] bt);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 20);
      if (gap != 0) begin
        s_axis_tvalid <= 0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {bt, id, et};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    burst_left = 0;
    @(negedge clk);
    while (sb.want_data.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic set_mode(bit m);
    cfg_we <= 1;
    cfg_data <= m;
    @(negedge clk);
    cfg_we <= 0;
    sb.mode = m;
  endtask

  task automatic random_phase(int n, int push_weight);
    repeat (n) begin
      if ($urandom_range(0, 99) < push_weight)
        send(1'b0, pick32(),
             $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 3)),
             pick32());
      else
        send(1'b1, $urandom, 16'($urandom), $urandom);
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    // directed: pop on empty, field extremes, ties in each mode
    send(1'b1, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send(1'b0, 32'hFFFF_FFFF, 16'hFFFF, 32'h0);
    send(1'b0, 32'h0, 16'h0, 32'hFFFF_FFFF);
    send(1'b0, 32'h5, 16'h2, 32'h5);
    send(1'b0, 32'h5, 16'h1, 32'h5);
    repeat (5) send(1'b1, '0, '0, '0);
    drain();
    set_mode(1);
    send(1'b0, 32'h9, 16'h3, 32'h7);
    send(1'b0, 32'h1, 16'h3, 32'h7);
    send(1'b0, 32'h1, 16'h2, 32'h7);
    send(1'b0, 32'hFFFF_FFFF, 16'hFFFF, 32'h1);
    repeat (5) send(1'b1, '0, '0, '0);
    drain();
    // fill past capacity: full drops, then mode flip with entries held
    random_phase(70, 100);
    drain();
    set_mode(0);
    random_phase(70, 0);
    drain();
    set_mode(1);
    random_phase(120, 60);
    drain();
    set_mode(0);
    random_phase(120, 55);
    drain();
    if (sb.errors == 0)
      $display("request_priority_heap_tb passed");
    else
      $display("request_priority_heap_tb failed");
    $finish;
  end
endmodule

FILE: request_priority_heap.f
rtl/core/rph_pkg.sv
rtl/core/rph_ram.sv
rtl/core/rph_ctrl.sv
rtl/core/rph_datapath.sv
rtl/core/request_priority_heap.sv
test/request_priority_heap_tb.sv
